### design/vmc_pkg.sv
// Package for the vector math coprocessor: state codes, command codes, and the command decode table.
`default_nettype none
package vmc_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_LOAD,
    ST_PREP,
    ST_RF1,
    ST_RF2,
    ST_RF3,
    ST_RS1,
    ST_RS2,
    ST_RS3,
    ST_DV0,
    ST_DV1,
    ST_DVE,
    ST_WN1,
    ST_WN2,
    ST_DS,
    ST_STORE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    K_LO,
    K_HI,
    K_SET,
    K_GET,
    K_EXEC,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] idx;
  } dec_t;

  localparam logic [1:0] MODE_CMD   = 2'd0;
  localparam logic [1:0] MODE_RD_LO = 2'd1;
  localparam logic [1:0] MODE_RD_HI = 2'd2;

  localparam logic [4:0] CMD_ROT_START  = 5'h0b;
  localparam logic [4:0] CMD_ROT_CONT   = 5'h11;
  localparam logic [4:0] CMD_ROT_SECOND = 5'h12;
  localparam logic [4:0] CMD_DIV_RES    = 5'h13;
  localparam logic [4:0] CMD_DIV_AB     = 5'h14;
  localparam logic [4:0] CMD_WINDOW     = 5'h1c;
  localparam logic [4:0] CMD_DIST_LOAD  = 5'h1d;
  localparam logic [4:0] CMD_DIST       = 5'h1e;

  localparam dec_t DEC_TABLE [32] = '{
    '{K_LO, 4'd0},   '{K_HI, 4'd0},   '{K_LO, 4'd1},   '{K_HI, 4'd1},
    '{K_LO, 4'd2},   '{K_HI, 4'd2},   '{K_LO, 4'd3},   '{K_HI, 4'd3},
    '{K_LO, 4'd4},   '{K_HI, 4'd4},   '{K_LO, 4'd5},   '{K_EXEC, 4'd0},
    '{K_SET, 4'd6},  '{K_LO, 4'd10},  '{K_HI, 4'd10},  '{K_LO, 4'd11},
    '{K_HI, 4'd11},  '{K_EXEC, 4'd0}, '{K_EXEC, 4'd0}, '{K_EXEC, 4'd0},
    '{K_EXEC, 4'd0}, '{K_LO, 4'd7},   '{K_HI, 4'd7},   '{K_GET, 4'd7},
    '{K_GET, 4'd9},  '{K_GET, 4'd8},  '{K_LO, 4'd8},   '{K_HI, 4'd8},
    '{K_EXEC, 4'd0}, '{K_EXEC, 4'd0}, '{K_EXEC, 4'd0}, '{K_NOP, 4'd0}
  };

endpackage
`default_nettype wire

### design/vmc_regfile.sv
// Scratch register memory: 16 x 16 bits, synchronous read, entries read as zero until written.
`default_nettype none
module vmc_regfile (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        we_i,
  input  wire logic [3:0]  waddr_i,
  input  wire logic [15:0] wdata_i,
  input  wire logic [3:0]  raddr_i,
  output logic      [15:0] rdata_o
);

  logic [15:0] mem [16];
  logic [15:0] rdata_q;
  logic [15:0] valid_q;
  logic        rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  // unwritten entries read as zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

### design/vector_math_coprocessor_top.sv
// Top level of the vector math coprocessor: command sequencer, datapath and output register.
//
// Usage: one input item per bus access (mode, command, write_byte) on the in_ channel,
// one result item (read_data, result_word) per access on the out_ channel. Both channels
// use valid/stall; an item moves at a clock edge with valid high and stall low.
// Result reads (modes 1..3) go from acceptance straight to the finishing state and on to
// the output register. Byte loads and register copies read the scratch entry, write it
// back (gets do not), finish, and return to idle, where the next item is taken. Computing
// commands copy all sixteen scratch registers out of the memory, run their steps on the
// working copy, and write all sixteen back. Rotation runs the first term, then the second
// and then division while R15 stays non-negative; the second-term command starts at the
// second term. Division runs a setup step, R6 + 1 iterations (one when R6 is negative,
// other than -32768) and an end step; the window test runs a sum and a test step per
// iteration. The single memory port pair moves one entry per cycle each way.
// One item is in work at a time; in_stall_o is high from acceptance until the result
// sits in the output register. A stalled result holds; the next item may be accepted
// while it waits, and its result waits in turn until the output register is free.
// Reset clears the control state and the result register; scratch entries read as zero
// until first written, so no clearing pass is needed.
`default_nettype none
module vector_math_coprocessor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_mode_i,
  input  wire logic [4:0]  in_command_i,
  input  wire logic [7:0]  in_write_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_read_data_o,
  output logic signed [15:0] out_result_word_o
);

  vmc_pkg::state_e state_q, state_d;
  logic [4:0]   cnt_q;
  logic [15:0]  result_q;
  logic         out_valid_q;
  logic [7:0]   read_data_q;
  logic [15:0]  result_word_q;

  logic [1:0]   mode_q;
  logic [4:0]   cmd_q;
  logic [7:0]   byte_q;
  vmc_pkg::dec_t dec_q;
  logic         divsel_q;

  logic [15:0]  wk_q [16];
  logic [31:0]  mprod_q;
  logic [31:0]  mp_q;
  logic [15:0]  d_q, q_q, c_q;

  logic         in_acc;
  logic         out_free;
  vmc_pkg::dec_t in_dec;

  // memory ports
  logic         mem_we;
  logic [3:0]   mem_waddr, mem_raddr;
  logic [15:0]  mem_wdata, mem_rdata;

  vmc_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_dec   = vmc_pkg::DEC_TABLE[in_command_i];

  // ---------------- shared multiplier ----------------
  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] mul_p;

  always_comb begin
    case (state_q)
      vmc_pkg::ST_RF2: begin
        mul_a = -{wk_q[1][15], wk_q[1]};
        mul_b = wk_q[5];
      end
      vmc_pkg::ST_RS1: begin
        mul_a = {wk_q[1][15], wk_q[1]};
        mul_b = wk_q[4];
      end
      vmc_pkg::ST_RS2: begin
        mul_a = {wk_q[0][15], wk_q[0]};
        mul_b = wk_q[5];
      end
      default: begin
        mul_a = {wk_q[0][15], wk_q[0]};
        mul_b = wk_q[4];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------- rotation terms ----------------
  logic [15:0] p_hi, p_lo, q_hi, q_lo;
  logic [15:0] f_r12, f_r14, f_sum, f_r7;
  logic [15:0] s_r9, s_r8;

  assign p_hi  = mp_q[31:16];
  assign p_lo  = mp_q[15:0];
  assign q_hi  = mprod_q[31:16];
  assign q_lo  = mprod_q[15:0];
  assign f_r14 = {1'b0, p_lo[15:1]};
  assign f_r12 = {1'b0, q_lo[15:1]};
  assign f_sum = f_r12 + f_r14;
  assign f_r7  = q_hi + p_hi + {15'd0, f_sum[15]};
  // second term: p is R1*R4, q is R0*R5; f_sum is the residue sum
  assign s_r9  = f_sum;
  assign s_r8  = q_hi + p_hi + {15'd0, s_r9[15]};

  // ---------------- division ----------------
  logic [15:0] dv_lo, dv_hi, dv_nlo, dv_d0, dv_q0, dv_c0;
  logic [15:0] dv_dm, dv_dn, dv_cnt;

  assign dv_lo  = divsel_q ? wk_q[10] : wk_q[9];
  assign dv_hi  = divsel_q ? wk_q[11] : wk_q[8];
  assign dv_nlo = ~dv_lo;
  assign dv_d0  = dv_hi[15]
                ? (~dv_hi + {15'd0, (dv_nlo[15] && (dv_nlo != 16'hffff))})
                : dv_hi;
  assign dv_q0  = dv_hi[15] ? (dv_nlo + 16'd1) : dv_lo;
  assign dv_c0  = wk_q[7][15] ? (16'd0 - wk_q[7]) : wk_q[7];
  assign dv_dm  = d_q - c_q;
  assign dv_dn  = dv_dm[15] ? d_q : dv_dm;
  assign dv_cnt = wk_q[15] - 16'd1;

  // ---------------- window test ----------------
  logic [16:0] wn_s4, wn_s5, wn_t;
  logic        wn_in;
  logic [15:0] wn_r6;

  assign wn_s4 = {wk_q[4][15], wk_q[4]} + {wk_q[7][15], wk_q[7]};
  assign wn_s5 = {wk_q[5][15], wk_q[5]} + {wk_q[8][15], wk_q[8]};
  assign wn_t  = {wk_q[14][15], wk_q[14]} + {wk_q[15][15], wk_q[15]};
  assign wn_in = ($signed(wk_q[11]) < $signed(wk_q[14])) &&
                 ($signed(wk_q[15]) < $signed(wk_q[14])) && !wn_t[16];
  assign wn_r6 = wk_q[6] - 16'd1;

  // ---------------- distance ----------------
  logic [15:0] ds_min, ds_max, ds_m4, ds_m8, ds_r13;

  assign ds_min = ($signed(wk_q[3]) >= $signed(wk_q[2])) ? wk_q[2] : wk_q[3];
  assign ds_max = ($signed(wk_q[3]) >= $signed(wk_q[2])) ? wk_q[3] : wk_q[2];
  assign ds_m4  = {{2{ds_min[15]}}, ds_min[15:2]};
  assign ds_m8  = {ds_m4[15], ds_m4[15:1]};
  assign ds_r13 = ds_max + ds_m4 + ds_m8;

  // ---------------- command preparation ----------------
  logic [15:0] pr_r5, pr_r3, pr_d2, pr_d3;

  assign pr_r5 = {byte_q, wk_q[5][7:0]};
  assign pr_r3 = {byte_q, wk_q[3][7:0]};
  assign pr_d2 = wk_q[2] - wk_q[0];
  assign pr_d3 = pr_r3 - wk_q[1];

  // ---------------- byte load ----------------
  logic [15:0] wr_val;

  always_comb begin
    case (dec_q.kind)
      vmc_pkg::K_LO:  wr_val = {mem_rdata[15:8], byte_q};
      vmc_pkg::K_HI:  wr_val = {byte_q, mem_rdata[7:0]};
      vmc_pkg::K_SET: wr_val = {8'd0, byte_q};
      default:        wr_val = mem_rdata;
    endcase
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      vmc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_mode_i != vmc_pkg::MODE_CMD) begin
            state_d = vmc_pkg::ST_DONE;
          end else begin
            case (in_dec.kind)
              vmc_pkg::K_EXEC: state_d = vmc_pkg::ST_LOAD;
              vmc_pkg::K_NOP:  state_d = vmc_pkg::ST_DONE;
              default:         state_d = vmc_pkg::ST_RD;
            endcase
          end
        end
      end
      vmc_pkg::ST_RD: state_d = vmc_pkg::ST_WR;
      vmc_pkg::ST_WR: state_d = vmc_pkg::ST_DONE;
      vmc_pkg::ST_LOAD: begin
        if (cnt_q == 5'd16) begin
          case (cmd_q)
            vmc_pkg::CMD_ROT_START, vmc_pkg::CMD_ROT_CONT,
            vmc_pkg::CMD_WINDOW, vmc_pkg::CMD_DIST_LOAD: state_d = vmc_pkg::ST_PREP;
            vmc_pkg::CMD_ROT_SECOND: state_d = vmc_pkg::ST_RS1;
            vmc_pkg::CMD_DIV_RES, vmc_pkg::CMD_DIV_AB: state_d = vmc_pkg::ST_DV0;
            vmc_pkg::CMD_DIST: state_d = vmc_pkg::ST_DS;
            default: state_d = vmc_pkg::ST_STORE;
          endcase
        end
      end
      vmc_pkg::ST_PREP: begin
        case (cmd_q)
          vmc_pkg::CMD_ROT_START, vmc_pkg::CMD_ROT_CONT: state_d = vmc_pkg::ST_RF1;
          vmc_pkg::CMD_WINDOW:    state_d = vmc_pkg::ST_WN1;
          vmc_pkg::CMD_DIST_LOAD: state_d = vmc_pkg::ST_DS;
          default:                state_d = vmc_pkg::ST_STORE;
        endcase
      end
      vmc_pkg::ST_RF1: state_d = vmc_pkg::ST_RF2;
      vmc_pkg::ST_RF2: state_d = vmc_pkg::ST_RF3;
      vmc_pkg::ST_RF3: state_d = wk_q[15][15] ? vmc_pkg::ST_STORE : vmc_pkg::ST_RS1;
      vmc_pkg::ST_RS1: state_d = vmc_pkg::ST_RS2;
      vmc_pkg::ST_RS2: state_d = vmc_pkg::ST_RS3;
      vmc_pkg::ST_RS3: state_d = wk_q[15][15] ? vmc_pkg::ST_STORE : vmc_pkg::ST_DV0;
      vmc_pkg::ST_DV0: state_d = vmc_pkg::ST_DV1;
      vmc_pkg::ST_DV1: state_d = dv_cnt[15] ? vmc_pkg::ST_DVE : vmc_pkg::ST_DV1;
      vmc_pkg::ST_DVE: state_d = vmc_pkg::ST_STORE;
      vmc_pkg::ST_WN1: state_d = vmc_pkg::ST_WN2;
      vmc_pkg::ST_WN2: state_d = wn_r6[15] ? vmc_pkg::ST_STORE : vmc_pkg::ST_WN1;
      vmc_pkg::ST_DS:  state_d = vmc_pkg::ST_STORE;
      vmc_pkg::ST_STORE: begin
        if (cnt_q[3:0] == 4'd15) begin
          state_d = vmc_pkg::ST_DONE;
        end
      end
      vmc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = vmc_pkg::ST_IDLE;
        end
      end
      default: state_d = vmc_pkg::ST_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = dec_q.idx;
    mem_wdata  = wr_val;
    mem_raddr  = dec_q.idx;
    case (state_q)
      vmc_pkg::ST_IDLE: in_stall_o = 1'b0;
      vmc_pkg::ST_LOAD: mem_raddr = cnt_q[3:0];
      vmc_pkg::ST_WR:   mem_we = (dec_q.kind != vmc_pkg::K_GET);
      vmc_pkg::ST_STORE: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[3:0];
        mem_wdata = wk_q[cnt_q[3:0]];
      end
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vmc_pkg::ST_IDLE;
      cnt_q       <= '0;
      result_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // sweep counter: advance while a load or store sweep continues
      if (((state_q == vmc_pkg::ST_LOAD) || (state_q == vmc_pkg::ST_STORE)) &&
          (state_d == state_q)) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
      case (state_q)
        vmc_pkg::ST_WR:  result_q <= wr_val;
        vmc_pkg::ST_RF3: result_q <= f_r7;
        vmc_pkg::ST_RS3: result_q <= s_r8;
        vmc_pkg::ST_DVE: result_q <= wk_q[14][15] ? (16'd0 - q_q) : q_q;
        vmc_pkg::ST_WN2: begin
          if (wn_r6[15]) begin
            result_q <= wn_in ? wk_q[15] : wk_q[8];
          end
        end
        vmc_pkg::ST_DS:  result_q <= ds_r13;
        default: ;
      endcase
      if (state_q == vmc_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= in_mode_i;
      cmd_q    <= in_command_i;
      byte_q   <= in_write_byte_i;
      dec_q    <= in_dec;
      divsel_q <= (in_command_i == vmc_pkg::CMD_DIV_AB);
    end
    if (state_q == vmc_pkg::ST_DONE && out_free) begin
      result_word_q <= result_q;
      case (mode_q)
        vmc_pkg::MODE_RD_LO: read_data_q <= result_q[7:0];
        vmc_pkg::MODE_RD_HI: read_data_q <= result_q[15:8];
        default:             read_data_q <= 8'd0;
      endcase
    end
    case (state_q)
      vmc_pkg::ST_LOAD: begin
        if (cnt_q != 5'd0) begin
          wk_q[4'(cnt_q - 5'd1)] <= mem_rdata;
        end
      end
      vmc_pkg::ST_PREP: begin
        case (cmd_q)
          vmc_pkg::CMD_ROT_START: begin
            wk_q[15] <= 16'hffff;
            wk_q[4]  <= wk_q[4] - wk_q[2];
            wk_q[5]  <= pr_r5 - wk_q[3];
          end
          vmc_pkg::CMD_ROT_CONT: begin
            wk_q[15] <= 16'h0000;
            wk_q[5]  <= pr_r5;
          end
          vmc_pkg::CMD_WINDOW: wk_q[5] <= pr_r5;
          default: begin
            wk_q[2] <= pr_d2[15] ? (16'd0 - pr_d2) : pr_d2;
            wk_q[3] <= pr_d3[15] ? (16'd0 - pr_d3) : pr_d3;
          end
        endcase
      end
      vmc_pkg::ST_RF1, vmc_pkg::ST_RS1: mprod_q <= mul_p[31:0];
      vmc_pkg::ST_RF2, vmc_pkg::ST_RS2: begin
        mp_q    <= mprod_q;
        mprod_q <= mul_p[31:0];
      end
      vmc_pkg::ST_RF3: begin
        wk_q[12] <= f_r12;
        wk_q[14] <= f_r14;
        wk_q[7]  <= wk_q[15][15] ? f_r7 : (f_r7 + wk_q[2]);
      end
      vmc_pkg::ST_RS3: begin
        wk_q[12] <= f_r12;
        if (wk_q[15][15]) begin
          wk_q[8] <= s_r8;
          wk_q[9] <= {s_r9[14:0], 1'b0};
        end else begin
          wk_q[8] <= s_r8 + wk_q[3];
          wk_q[9] <= {s_r9[14:7], 8'd0};
        end
      end
      vmc_pkg::ST_DV0: begin
        wk_q[14] <= wk_q[7] ^ dv_hi;
        wk_q[12] <= dv_c0;
        wk_q[15] <= wk_q[6];
        d_q      <= dv_d0;
        q_q      <= dv_q0;
        c_q      <= dv_c0;
      end
      vmc_pkg::ST_DV1: begin
        // one restoring subtract step
        d_q      <= {dv_dn[14:0], q_q[15]};
        q_q      <= {q_q[14:0], ~dv_dm[15]};
        wk_q[15] <= dv_cnt;
      end
      vmc_pkg::ST_DVE: wk_q[13] <= d_q;
      vmc_pkg::ST_WN1: begin
        wk_q[14] <= wn_s4[16:1];
        wk_q[15] <= wn_s5[16:1];
      end
      vmc_pkg::ST_WN2: begin
        if (wn_in) begin
          wk_q[7] <= wk_q[14];
          wk_q[8] <= wk_q[15];
        end else begin
          wk_q[4] <= wk_q[14];
          wk_q[5] <= wk_q[15];
        end
        wk_q[6] <= wn_r6;
      end
      vmc_pkg::ST_DS: begin
        wk_q[12] <= ds_m8;
        wk_q[13] <= ds_r13;
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign out_read_data_o   = read_data_q;
  assign out_result_word_o = result_word_q;

  // ---------------- assertions ----------------
  a_read_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_mode_i != vmc_pkg::MODE_CMD) |=> state_q == vmc_pkg::ST_DONE)
    else $error("result read did not go straight to completion");

  a_store_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vmc_pkg::ST_STORE) && (cnt_q[3:0] == 4'd15) |=> state_q == vmc_pkg::ST_DONE)
    else $error("write-back sweep did not end after sixteen entries");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vmc_pkg::ST_DONE) && out_free |=> out_valid_q && (state_q == vmc_pkg::ST_IDLE))
    else $error("finished item did not reach the output register");

  a_mem_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == vmc_pkg::ST_WR) || (state_q == vmc_pkg::ST_STORE))
    else $error("scratch memory written outside a write step");

endmodule
`default_nettype wire
